// ===== design/phbp_pkg.sv =====
package phbp_pkg;

	// Table geometry.
	localparam int INDEX_BITS    = 14;
	localparam int HISTORY_BITS  = 2;
	localparam int COUNTER_WIDTH = 2;
	localparam int TABLE_BITS    = INDEX_BITS + HISTORY_BITS;
	localparam int TABLE_DEPTH   = 1 << TABLE_BITS;

	// Threshold register width and the width used to compare it with a counter.
	localparam int THR_BITS = 2;
	localparam int CMP_BITS = (COUNTER_WIDTH > THR_BITS) ? COUNTER_WIDTH : THR_BITS;

	typedef logic [INDEX_BITS-1:0]    addr_t;
	typedef logic [TABLE_BITS-1:0]    idx_t;
	typedef logic [HISTORY_BITS-1:0]  hist_t;
	typedef logic [COUNTER_WIDTH-1:0] ctr_t;
	typedef logic [THR_BITS-1:0]      thr_t;

	localparam ctr_t CTR_MAX   = '1;
	localparam thr_t THR_RESET = thr_t'(1);

	// Command codes carried in the cmd field.
	localparam logic CMD_PREDICT = 1'b0;
	localparam logic CMD_UPDATE  = 1'b1;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

endpackage

// ===== design/phbp_ifaces.sv =====
// Request channel: one predict or update word.
interface phbp_req_if import phbp_pkg::*;;
	logic  valid;
	logic  ready;
	logic  cmd;
	addr_t branch_address;
	logic  outcome_taken;

	modport source(output valid, cmd, branch_address, outcome_taken, input ready);
	modport sink(input valid, cmd, branch_address, outcome_taken, output ready);
endinterface

// Response channel: one prediction word.
interface phbp_rsp_if;
	logic valid;
	logic ready;
	logic predict_taken;

	modport source(output valid, predict_taken, input ready);
	modport sink(input valid, predict_taken, output ready);
endinterface

// Configuration channel: writes the taken threshold.
interface phbp_cfg_if import phbp_pkg::*;;
	logic valid;
	logic ready;
	thr_t data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// ===== design/pc_history_branch_predictor.sv =====
// Flow: a predict word is read from the counter table when it is accepted on req, and
// the prediction is loaded into the output register once that register is free.
// The block takes one word at a time: req is not ready again until that word is done;
// the table is read at acceptance and an update word's counter written back in the next.
// Reset: arst_n clears history, threshold (to 1) and control, then a clearing pass
// zeroes all 65536 entries of the counter table; req is not ready during that pass.
module pc_history_branch_predictor
	import phbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	phbp_req_if.sink    req,
	phbp_rsp_if.source  rsp,
	phbp_cfg_if.sink    cfg
);

	state_t state_q, state_d;

	idx_t  clr_idx_q;
	hist_t hist_q;
	thr_t  thr_q;

	// Word captured at acceptance.
	idx_t  idx_s1;
	logic  cmd_s1;
	logic  taken_s1;

	// Counter memory.
	ctr_t  mem [TABLE_DEPTH];
	ctr_t  rd_data_s1;
	logic  mem_we;
	idx_t  mem_waddr;
	ctr_t  mem_wdata;

	// Output register.
	logic  out_valid_q;
	logic  out_data_q;

	logic  req_fire;
	logic  out_free;
	logic  load_out;
	logic  do_update;
	logic  predict_bit;
	ctr_t  ctr_next;

	assign req_fire = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.predict_taken = out_data_q;

	// Counter arithmetic on the word read from the table.
	always_comb begin
		predict_bit = (CMP_BITS'(rd_data_s1) >= CMP_BITS'(thr_q));
		if (taken_s1) begin
			ctr_next = (rd_data_s1 != CTR_MAX) ? ctr_t'(rd_data_s1 + 1'b1) : rd_data_s1;
		end else begin
			ctr_next = (rd_data_s1 != '0) ? ctr_t'(rd_data_s1 - 1'b1) : rd_data_s1;
		end
	end

	// Next state and control outputs.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		load_out  = 1'b0;
		do_update = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = ctr_next;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
				mem_wdata = '0;
				if (clr_idx_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (cmd_s1 == CMD_UPDATE) begin
					do_update = 1'b1;
					mem_we    = 1'b1;
					state_d   = ST_IDLE;
				end else if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, history, threshold and output control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			hist_q      <= '0;
			thr_q       <= THR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= idx_t'(clr_idx_q + 1'b1);
			end
			if (do_update) begin
				hist_q <= hist_t'({hist_q, taken_s1});
			end
			if (cfg.valid) begin
				thr_q <= cfg.data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			idx_s1   <= {req.branch_address, hist_q};
			cmd_s1   <= req.cmd;
			taken_s1 <= req.outcome_taken;
		end
		if (load_out) begin
			out_data_q <= predict_bit;
		end
	end

	// Counter table: one write, one registered read issued at acceptance.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (req_fire) begin
			rd_data_s1 <= mem[{req.branch_address, hist_q}];
		end
	end

`ifndef SYNTHESIS
	// No word enters while the table is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.ready)
		else $error("request accepted during clearing pass");

	// A lookup writes the table only for an update word.
	a_write_only_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP && mem_we) |-> (cmd_s1 == CMD_UPDATE))
		else $error("table written by a predict word");

	// A response appears only after a predict lookup.
	a_rsp_from_predict: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_LOOKUP && cmd_s1 == CMD_PREDICT))
		else $error("response without a predict lookup");

	// History moves only on an update lookup.
	a_hist_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(hist_q) |-> $past(state_q == ST_LOOKUP && cmd_s1 == CMD_UPDATE))
		else $error("history changed without an update");
`endif

endmodule
